// ----- hw/rtl/pcclb_pkg.sv -----
package pcclb_pkg;

    // Sizing of the channel array and of one line.
    localparam int LINE_BYTES   = 64;
    localparam int MAX_CORES    = 16;
    localparam int MAX_CLUSTERS = 4;
    localparam int CHANNELS     = MAX_CORES * MAX_CLUSTERS;

    localparam int POS_W       = $clog2(LINE_BYTES);
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int STORE_AW    = CH_W + POS_W;
    localparam int STORE_DEPTH = CHANNELS * LINE_BYTES;

    // Fixed field widths of the bus beats.
    localparam int OFFSET_W    = 13;
    localparam int BYTE_W      = 8;
    localparam int CORE_W      = 4;
    localparam int CLUS_W      = 6;
    localparam int OUT_CORE_W  = 4;
    localparam int OUT_CLUS_W  = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;

    // Configuration register widths and indexes.
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 6;
    localparam int CPC_W       = 5;
    localparam int CCNT_W      = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_CORES_PER_CLUSTER    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CLUSTER_COUNT        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CORE_FIXED_ENABLE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CORE_FIXED_ID        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CLUSTER_FIXED_ENABLE = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CLUSTER_FIXED_ID     = 3'd5;

    // Beat kinds and response status codes.
    localparam logic KIND_RESP      = 1'b0;
    localparam logic KIND_BYTE      = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    localparam logic [BYTE_W-1:0] NL_BYTE = 8'h0A;

    // Result of the channel decode for one access.
    typedef struct packed {
        logic [CORE_W-1:0] core;
        logic [CLUS_W-1:0] cluster;
        logic [CH_W-1:0]   ch;
        logic              invalid;
    } chan_sel_t;

    typedef struct packed {
        logic [CPC_W-1:0]  cores_per_cluster;
        logic [CCNT_W-1:0] cluster_count;
        logic              core_fixed_enable;
        logic [CORE_W-1:0] core_fixed_id;
        logic              cluster_fixed_enable;
        logic [CLUS_W-1:0] cluster_fixed_id;
    } cfg_t;

endpackage

// ----- hw/rtl/per_channel_console_line_buffer_core.sv -----
// Console line buffer with one line per (cluster, core) channel. Every input
// beat is one bus access carrying an offset and a byte; it produces a response
// beat (tuser = 0) and, when the byte is a newline or the line reaches
// LINE_BYTES-1 bytes, the buffered line as a run of byte beats (tuser = 1)
// that ends with tlast. A response with nothing flushed carries tlast itself.
// Accesses are handled one at a time: each access passes through a registered
// read of the fill-position memory and a response state, and a flush then
// drains the line from the single read port of the line store, one byte per
// cycle while the output is not stalled. No clearing pass is needed after
// reset: per-channel valid bits mark the fill positions that have been written.
module per_channel_console_line_buffer_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [12:0] offset, [20:13] char_byte, [23:21] zero
    input  logic [pcclb_pkg::S_TDATA_W-1:0]     s_tdata,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] status, [8:1] out_byte, [12:9] out_core, [14:13] out_cluster, [15] zero
    output logic [pcclb_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] kind
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,

    input  logic                                cfg_wr_en,
    input  logic [pcclb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pcclb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // One-hot sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_POS   = 4'b0010,
        ST_RESP  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    pcclb_pkg::cfg_t cfg_reg;

    // Access being worked on.
    pcclb_pkg::chan_sel_t            sel_in;
    pcclb_pkg::chan_sel_t            sel_reg;
    logic [pcclb_pkg::BYTE_W-1:0]    byte_reg;
    logic                            flush_reg;
    logic [pcclb_pkg::POS_W-1:0]     count_reg;
    logic [pcclb_pkg::POS_W-1:0]     idx_reg, idx_next;

    // Fill position per channel, with valid bits standing for the zero reset.
    logic [pcclb_pkg::POS_W-1:0]     fill_mem [pcclb_pkg::CHANNELS];
    logic [pcclb_pkg::POS_W-1:0]     fill_rdata_reg;
    logic [pcclb_pkg::CHANNELS-1:0]  fill_valid_reg;

    // Line store, addressed by {channel, position}.
    logic [pcclb_pkg::BYTE_W-1:0]    store_mem [pcclb_pkg::STORE_DEPTH];
    logic [pcclb_pkg::BYTE_W-1:0]    store_rdata_reg;
    logic                            store_rd_en;
    logic [pcclb_pkg::STORE_AW-1:0]  store_rd_addr;
    logic [pcclb_pkg::STORE_AW-1:0]  store_wr_addr;

    // Output register.
    logic                            m_tvalid_reg;
    logic [pcclb_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                            m_tuser_reg;
    logic                            m_tlast_reg;

    logic                            s_accept;
    logic                            out_free;
    logic                            out_load;
    logic [pcclb_pkg::M_TDATA_W-1:0] out_data;
    logic                            out_kind;
    logic                            out_last;

    logic [pcclb_pkg::POS_W-1:0]     pos_raw;
    logic [pcclb_pkg::POS_W-1:0]     pos_cur;
    logic [pcclb_pkg::POS_W-1:0]     pos_inc;
    logic                            do_flush;
    logic                            drain_last;

    pcclb_chan_sel u_chan_sel (
        .offset (s_tdata[pcclb_pkg::OFFSET_W-1:0]),
        .cfg    (cfg_reg),
        .sel    (sel_in)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Position update for the channel whose fill position was just read.
    always_comb begin
        pos_raw  = fill_valid_reg[sel_reg.ch] ? fill_rdata_reg : '0;
        pos_cur  = (32'(pos_raw) >= pcclb_pkg::LINE_BYTES - 1) ? '0 : pos_raw;
        pos_inc  = pos_cur + 1'b1;
        do_flush = (byte_reg == pcclb_pkg::NL_BYTE)
                || (32'(pos_inc) == pcclb_pkg::LINE_BYTES - 1);
    end

    assign store_wr_addr = {sel_reg.ch, pos_cur};
    assign drain_last    = ((idx_reg + 1'b1) == count_reg);

    // Sequencer and the output beat it loads.
    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        store_rd_en   = 1'b0;
        store_rd_addr = {sel_reg.ch, idx_reg};
        out_load      = 1'b0;
        out_kind      = pcclb_pkg::KIND_RESP;
        out_last      = 1'b1;
        out_data      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_POS;
                end
            end
            ST_POS: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                out_data = {1'b0,
                            sel_reg.cluster[pcclb_pkg::OUT_CLUS_W-1:0],
                            sel_reg.core[pcclb_pkg::OUT_CORE_W-1:0],
                            {pcclb_pkg::BYTE_W{1'b0}},
                            sel_reg.invalid ? pcclb_pkg::STATUS_INVALID
                                            : pcclb_pkg::STATUS_OK};
                out_kind = pcclb_pkg::KIND_RESP;
                out_last = !flush_reg;
                if (out_free) begin
                    out_load = 1'b1;
                    if (flush_reg) begin
                        idx_next      = '0;
                        store_rd_en   = 1'b1;
                        store_rd_addr = {sel_reg.ch, {pcclb_pkg::POS_W{1'b0}}};
                        state_next    = ST_DRAIN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DRAIN: begin
                out_data = {1'b0,
                            sel_reg.cluster[pcclb_pkg::OUT_CLUS_W-1:0],
                            sel_reg.core[pcclb_pkg::OUT_CORE_W-1:0],
                            store_rdata_reg,
                            pcclb_pkg::STATUS_OK};
                out_kind = pcclb_pkg::KIND_BYTE;
                out_last = drain_last;
                if (out_free) begin
                    out_load = 1'b1;
                    if (drain_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next      = idx_reg + 1'b1;
                        store_rd_en   = 1'b1;
                        store_rd_addr = {sel_reg.ch, idx_reg + 1'b1};
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            fill_valid_reg <= '0;
            cfg_reg.cores_per_cluster    <= pcclb_pkg::CPC_W'(1);
            cfg_reg.cluster_count        <= pcclb_pkg::CCNT_W'(1);
            cfg_reg.core_fixed_enable    <= 1'b0;
            cfg_reg.core_fixed_id        <= '0;
            cfg_reg.cluster_fixed_enable <= 1'b0;
            cfg_reg.cluster_fixed_id     <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == ST_POS && !sel_reg.invalid) begin
                fill_valid_reg[sel_reg.ch] <= 1'b1;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    pcclb_pkg::REG_CORES_PER_CLUSTER:
                        cfg_reg.cores_per_cluster <= cfg_wdata[pcclb_pkg::CPC_W-1:0];
                    pcclb_pkg::REG_CLUSTER_COUNT:
                        cfg_reg.cluster_count <= cfg_wdata[pcclb_pkg::CCNT_W-1:0];
                    pcclb_pkg::REG_CORE_FIXED_ENABLE:
                        cfg_reg.core_fixed_enable <= cfg_wdata[0];
                    pcclb_pkg::REG_CORE_FIXED_ID:
                        cfg_reg.core_fixed_id <= cfg_wdata[pcclb_pkg::CORE_W-1:0];
                    pcclb_pkg::REG_CLUSTER_FIXED_ENABLE:
                        cfg_reg.cluster_fixed_enable <= cfg_wdata[0];
                    pcclb_pkg::REG_CLUSTER_FIXED_ID:
                        cfg_reg.cluster_fixed_id <= cfg_wdata[pcclb_pkg::CLUS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (s_accept) begin
            sel_reg  <= sel_in;
            byte_reg <= s_tdata[pcclb_pkg::OFFSET_W +: pcclb_pkg::BYTE_W];
        end
        if (state_reg == ST_POS) begin
            flush_reg <= !sel_reg.invalid && do_flush;
            count_reg <= pos_inc;
        end
        if (out_load) begin
            m_tdata_reg <= out_data;
            m_tuser_reg <= out_kind;
            m_tlast_reg <= out_last;
        end
    end

    // Fill-position memory: read on acceptance, written back in the next cycle, the position state.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fill_rdata_reg <= fill_mem[sel_in.ch];
        end
        if (state_reg == ST_POS && !sel_reg.invalid) begin
            fill_mem[sel_reg.ch] <= do_flush ? '0 : pos_inc;
        end
    end

    // Line store: the byte is written in the position cycle, and a flush
    // reads the line back one byte per cycle while the output is not stalled.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_POS && !sel_reg.invalid) begin
            store_mem[store_wr_addr] <= byte_reg;
        end
        if (store_rd_en) begin
            store_rdata_reg <= store_mem[store_rd_addr];
        end
    end

endmodule

// ----- hw/rtl/pcclb_chan_sel.sv -----
// Picks the core and cluster of an access and checks them against the
// configured channel range.
module pcclb_chan_sel (
    input  logic [pcclb_pkg::OFFSET_W-1:0] offset,
    input  pcclb_pkg::cfg_t                cfg,
    output pcclb_pkg::chan_sel_t           sel
);

    logic [pcclb_pkg::CORE_W-1:0] core;
    logic [pcclb_pkg::CLUS_W-1:0] cluster;
    logic                         core_bad;
    logic                         clus_bad;

    always_comb begin
        core    = cfg.core_fixed_enable ? cfg.core_fixed_id : offset[6:3];
        cluster = cfg.cluster_fixed_enable ? cfg.cluster_fixed_id : offset[12:7];

        core_bad = (32'(core) >= 32'(cfg.cores_per_cluster))
                || (32'(core) >= pcclb_pkg::MAX_CORES);
        clus_bad = (32'(cluster) >= 32'(cfg.cluster_count))
                || (32'(cluster) >= pcclb_pkg::MAX_CLUSTERS);

        sel.core    = core;
        sel.cluster = cluster;
        sel.ch      = pcclb_pkg::CH_W'(32'(cluster) * pcclb_pkg::MAX_CORES + 32'(core));
        sel.invalid = core_bad || clus_bad;
    end

endmodule

// ----- hw/rtl/pcclb_checker.sv -----
// Port-level checks for the console line buffer.
module pcclb_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pcclb_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]                       m_tuser
    ,
    input logic                             m_tlast
);

    // A stalled output beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

    // Accesses are taken one at a time.
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // An invalid-channel response never starts a flush.
    a_invalid_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == pcclb_pkg::KIND_RESP
            && m_tdata[0] == pcclb_pkg::STATUS_INVALID) |-> m_tlast)
        else $error("invalid response without last");

    // Flushed bytes carry an ok status.
    a_byte_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == pcclb_pkg::KIND_BYTE)
            |-> (m_tdata[0] == pcclb_pkg::STATUS_OK))
        else $error("flushed byte with non-ok status");

    // Responses carry no byte.
    a_resp_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == pcclb_pkg::KIND_RESP) |-> (m_tdata[8:1] == 8'h00))
        else $error("response with nonzero byte");

endmodule

bind per_channel_console_line_buffer_core pcclb_checker u_pcclb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- tb/tb_per_channel_console_line_buffer_core.sv -----
module tb_per_channel_console_line_buffer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pcclb_pkg::*;

    // One output beat as the checker sees it. The fields are unpacked from
    // m_tdata, m_tuser and m_tlast.
    typedef struct packed {
        logic              kind;
        logic              status;
        logic [BYTE_W-1:0] data;
        logic [3:0]        core;
        logic [1:0]        cluster;
        logic              last;
    } console_beat_t;

    // All block inputs start at a known value before the first clock edge.
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // [12:0] offset, [20:13] char_byte, [23:21] zero
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [0] status, [8:1] out_byte, [12:9] out_core, [14:13] out_cluster, [15] zero
    logic [M_TDATA_W-1:0]   m_tdata;
    // [0] kind
    logic [0:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Shadow of the block: its registers, the bytes of every open line and
    // the fill position of each channel.
    cfg_t                   mirror_cfg;
    logic [BYTE_W-1:0]      line_mem [CHANNELS][LINE_BYTES];
    int                     fill_pos [CHANNELS];

    // Beats that the accepted accesses have caused and that have not yet
    // shown up on the master side, oldest first.
    console_beat_t          due_beats[$];
    console_beat_t          head;
    int                     mismatches = 0;

    // While set, neither side inserts idle cycles.
    bit                     quiet = 1'b0;

    per_channel_console_line_buffer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 20 ns clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Hard stop in case the block hangs. The slowest legal run of a few
    // hundred accesses, each flushing a full line into a stalling sink, stays
    // far below this.
    initial begin
        #20_000_000;
        $display("tb_per_channel_console_line_buffer_core: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    // Register values outside their range never widen the channel set, so
    // the counts are clamped to the array size.
    function automatic int core_limit();
        return (mirror_cfg.cores_per_cluster < MAX_CORES) ?
               int'(mirror_cfg.cores_per_cluster) : MAX_CORES;
    endfunction

    function automatic int cluster_limit();
        return (mirror_cfg.cluster_count < MAX_CLUSTERS) ?
               int'(mirror_cfg.cluster_count) : MAX_CLUSTERS;
    endfunction

    // Appends one beat at the tail of the due list.
    function automatic void queue_beat(console_beat_t nb);
        due_beats = {due_beats, nb};
    endfunction

    // Applies one accepted access to the shadow and queues the beats it
    // causes: the response first, then the whole line if it was flushed.
    function automatic void apply_access(logic [OFFSET_W-1:0] offset,
                                         logic [BYTE_W-1:0] ch_byte);
        logic [CORE_W-1:0] sel_core;
        logic [CLUS_W-1:0] sel_cluster;
        int                ch;
        int                pos;
        console_beat_t     b;
        sel_core    = mirror_cfg.core_fixed_enable ? mirror_cfg.core_fixed_id : offset[6:3];
        sel_cluster = mirror_cfg.cluster_fixed_enable ? mirror_cfg.cluster_fixed_id
                                                      : offset[12:7];
        // The response carries the selected ids cut to the output widths,
        // also for an invalid channel.
        b.kind    = KIND_RESP;
        b.status  = STATUS_OK;
        b.data    = '0;
        b.core    = sel_core;
        b.cluster = sel_cluster[1:0];
        b.last    = 1'b1;
        if (sel_core >= core_limit() || sel_cluster >= cluster_limit()) begin
            b.status = STATUS_INVALID;
            queue_beat(b);
            return;
        end
        ch  = int'(sel_cluster) * MAX_CORES + int'(sel_core);
        pos = fill_pos[ch];
        if (pos >= LINE_BYTES - 1)
            pos = 0;
        line_mem[ch][pos] = ch_byte;
        pos++;
        if (ch_byte != NL_BYTE && pos != LINE_BYTES - 1) begin
            fill_pos[ch] = pos;
            queue_beat(b);
            return;
        end
        // Flush: the response loses its last mark to the final line byte.
        b.last = 1'b0;
        queue_beat(b);
        for (int i = 0; i < pos; i++) begin
            b.kind = KIND_BYTE;
            b.data = line_mem[ch][i];
            b.last = (i == pos - 1);
            queue_beat(b);
        end
        fill_pos[ch] = 0;
    endfunction

    // ------------------------------------------------------------------
    // Master side: random back-pressure and the beat checker
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 18);
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    // Outputs are sampled at the rising edge, before the block updates them.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_beats.size() == 0) begin
                mismatches++;
                $display("%0t ns: beat with nothing due, expected none, actual tuser %0h tdata %0h",
                         $time, m_tuser, m_tdata);
            end else begin
                head = due_beats.pop_front();
                check_field("kind",        8'(head.kind),    8'(m_tuser[0]));
                check_field("status",      8'(head.status),  8'(m_tdata[0]));
                check_field("out_byte",    head.data,        m_tdata[8:1]);
                check_field("out_core",    8'(head.core),    8'(m_tdata[12:9]));
                check_field("out_cluster", 8'(head.cluster), 8'(m_tdata[14:13]));
                check_field("last",        8'(head.last),    8'(m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // Slave side and configuration
    // ------------------------------------------------------------------

    function automatic logic [OFFSET_W-1:0] make_offset(int core, int cluster, int low);
        return {CLUS_W'(cluster), CORE_W'(core), 3'(low)};
    endfunction

    // Offers one access and returns at the edge where it is taken. The valid
    // stays up afterwards, so back-to-back calls stream without a bubble;
    // settle_idle lowers it when the stream stops.
    task automatic send_access(logic [OFFSET_W-1:0] offset, logic [BYTE_W-1:0] ch_byte);
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, ch_byte, offset};
        do @(posedge aclk); while (!s_tready);
        apply_access(offset, ch_byte);
    endtask

    // Stops the stream and waits until every due beat has arrived. The extra
    // wait covers the block's turnaround after its last beat, so a register
    // write that follows lands while it is idle.
    task automatic settle_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CORES_PER_CLUSTER:    mirror_cfg.cores_per_cluster    = value[CPC_W-1:0];
            REG_CLUSTER_COUNT:        mirror_cfg.cluster_count        = value[CCNT_W-1:0];
            REG_CORE_FIXED_ENABLE:    mirror_cfg.core_fixed_enable    = value[0];
            REG_CORE_FIXED_ID:        mirror_cfg.core_fixed_id        = value[CORE_W-1:0];
            REG_CLUSTER_FIXED_ENABLE: mirror_cfg.cluster_fixed_enable = value[0];
            REG_CLUSTER_FIXED_ID:     mirror_cfg.cluster_fixed_id     = value[CLUS_W-1:0];
            default: ;
        endcase
    endtask

    // Drains the block, then rewrites all six registers.
    task automatic set_config(int cpc, int ccnt, int core_en, int core_id,
                              int clus_en, int clus_id);
        settle_idle();
        write_reg(REG_CORES_PER_CLUSTER,    CFG_DATA_W'(cpc));
        write_reg(REG_CLUSTER_COUNT,        CFG_DATA_W'(ccnt));
        write_reg(REG_CORE_FIXED_ENABLE,    CFG_DATA_W'(core_en));
        write_reg(REG_CORE_FIXED_ID,        CFG_DATA_W'(core_id));
        write_reg(REG_CLUSTER_FIXED_ENABLE, CFG_DATA_W'(clus_en));
        write_reg(REG_CLUSTER_FIXED_ID,     CFG_DATA_W'(clus_id));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // After reset only core 0 of cluster 0 is in use.
    task automatic test_reset_defaults();
        send_access(make_offset(0, 0, 0), 8'h41);
        send_access(make_offset(1, 0, 0), 8'h42);   // core out of range
        send_access(make_offset(0, 1, 7), 8'h43);   // cluster out of range
        send_access(make_offset(0, 0, 5), NL_BYTE); // flushes the two-byte line
    endtask

    // Full channel set: field extremes, ids that need masking, newline on an
    // empty line, and an invalid newline that must store nothing.
    task automatic test_channel_extremes();
        set_config(MAX_CORES, MAX_CLUSTERS, 0, 0, 0, 0);
        send_access(13'h0000, 8'h00);
        send_access(13'h1FFF, 8'hFF);               // cluster 63: invalid, id masked
        send_access(make_offset(15, 3, 7), 8'hFF);
        send_access(make_offset(15, 3, 0), NL_BYTE);
        send_access(make_offset(0, 0, 0), NL_BYTE); // line holds the zero byte
        send_access(make_offset(7, 2, 3), NL_BYTE); // newline alone on a line
        send_access(make_offset(8, 1, 0), 8'h80);
        send_access(13'h1000, NL_BYTE);             // cluster 32 masks to 0, invalid
        send_access(make_offset(8, 4, 0), 8'h55);   // first cluster past the range
        send_access(make_offset(8, 1, 6), NL_BYTE);
    endtask

    // Counts of zero and counts beyond the array size.
    task automatic test_register_limits();
        set_config(0, MAX_CLUSTERS, 0, 0, 0, 0);
        send_access(make_offset(0, 0, 0), 8'h30);
        send_access(make_offset(0, 0, 0), NL_BYTE);
        set_config(MAX_CORES, 0, 0, 0, 0, 0);
        send_access(make_offset(0, 0, 0), 8'h31);
        set_config(31, 7, 0, 0, 0, 0);
        send_access(make_offset(15, 3, 1), 8'h32);
        send_access(make_offset(15, 4, 1), 8'h33);
        send_access(make_offset(15, 3, 2), NL_BYTE);
        set_config(5, 2, 0, 0, 0, 0);
        send_access(make_offset(5, 0, 0), 8'h34);
        send_access(make_offset(4, 1, 0), NL_BYTE);
    endtask

    // The id overrides, alone and together, valid and out of range.
    task automatic test_overrides();
        set_config(MAX_CORES, MAX_CLUSTERS, 1, 15, 1, 3);
        send_access(13'h1FFF, 8'h61);
        send_access(13'h0000, NL_BYTE);
        set_config(MAX_CORES, MAX_CLUSTERS, 1, 9, 0, 0);
        send_access(make_offset(0, 2, 0), 8'h62);
        send_access(make_offset(15, 2, 0), NL_BYTE);
        set_config(MAX_CORES, MAX_CLUSTERS, 0, 0, 1, 31);
        send_access(make_offset(3, 0, 0), 8'h63);
        set_config(4, MAX_CLUSTERS, 1, 12, 0, 0);
        send_access(make_offset(1, 1, 0), 8'h64);
    endtask

    // A line that never sees a newline flushes by itself once it holds
    // LINE_BYTES-1 bytes; the remainder then starts a fresh line. This runs
    // without idle cycles on either side.
    task automatic test_full_line();
        logic [BYTE_W-1:0] b;
        set_config(MAX_CORES, MAX_CLUSTERS, 0, 0, 0, 0);
        quiet = 1'b1;
        for (int i = 0; i < LINE_BYTES + 6; i++) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == NL_BYTE)
                b = 8'h20;
            send_access(make_offset(3, 1, i), b);
        end
        send_access(make_offset(3, 1, 0), NL_BYTE);
        settle_idle();
        quiet = 1'b0;
    endtask

    // Several random settings. Most accesses write lines into a small pool
    // of valid channels so that lines build up and flush while interleaved;
    // the rest hit invalid channels or are fully random.
    task automatic test_random_traffic();
        int                cpc, ccnt;
        int                pool_core [3];
        int                pool_cluster [3];
        int                p, r;
        logic [OFFSET_W-1:0] offset;
        logic [BYTE_W-1:0]   b;
        for (int phase = 0; phase < 6; phase++) begin
            cpc  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
            ccnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            set_config(cpc, ccnt,
                       $urandom_range(0, 4) == 0, $urandom_range(0, 15),
                       $urandom_range(0, 4) == 0,
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(0, 3));
            for (int k = 0; k < 3; k++) begin
                pool_core[k]    = (core_limit() > 0) ? $urandom_range(0, core_limit() - 1) : 0;
                pool_cluster[k] = (cluster_limit() > 0) ?
                                  $urandom_range(0, cluster_limit() - 1) : 0;
            end
            quiet = (phase == 1);
            for (int n = 0; n < 20; n++) begin
                r = $urandom_range(0, 99);
                b = BYTE_W'($urandom_range(0, 255));
                if (r < 70) begin
                    p = $urandom_range(0, 2);
                    offset = make_offset(pool_core[p], pool_cluster[p], $urandom_range(0, 7));
                    if ($urandom_range(0, 7) == 0)
                        b = NL_BYTE;
                end else if (r < 85) begin
                    offset = make_offset($urandom_range(0, 15),
                                         $urandom_range(cluster_limit(), 63),
                                         $urandom_range(0, 7));
                end else begin
                    offset = OFFSET_W'($urandom_range(0, 8191));
                end
                send_access(offset, b);
                // Once, hold the sender until everything due has come out.
                if (phase == 3 && n == 17)
                    settle_idle();
            end
            quiet = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        mirror_cfg = '0;
        mirror_cfg.cores_per_cluster = 1;
        mirror_cfg.cluster_count     = 1;

        // Reset is released at a falling edge and is never asserted again.
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_channel_extremes();
        test_register_limits();
        test_overrides();
        test_full_line();
        test_random_traffic();

        // Everything due must arrive, and nothing more may follow.
        settle_idle();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && due_beats.size() == 0)
            $display("tb_per_channel_console_line_buffer_core: clean");
        else
            $display("tb_per_channel_console_line_buffer_core: errors");
        $finish;
    end

endmodule
